// File: rtl/core/obf_pkg.sv
package obf_pkg;

  // Default sizes
  localparam int DEF_CAPACITY          = 256;
  localparam int DEF_MAX_ELEMENT_BYTES = 8;

  // Fixed field widths
  localparam int DATA_W  = 64;
  localparam int ELEM_W  = 4;
  localparam int SIZE_W  = 9;
  localparam int CIDX_W  = 1;
  localparam int CDATA_W = 9;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_ELEMENT_BYTES = 1'd0;
  localparam logic [CIDX_W-1:0] REG_RING_SIZE     = 1'd1;

  // Request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_POP,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;      // latch request, clear byte counter and gather word
    logic push_step;  // write one byte, advance count or head
    logic pop_step;   // read one byte at head, advance head
    logic load_out;   // move result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic elem_zero;      // element size is zero
    logic empty;          // no bytes stored
    logic last_idx;       // current byte is the last of the element
    logic last_pop_byte;  // one byte left stored
    logic out_free;       // output register can take a word
  } dp_status_t;

endpackage

// File: rtl/core/obf_ctrl.sv
module obf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                req_type,
  output logic                in_ready,
  input  obf_pkg::dp_status_t status,
  output obf_pkg::ctrl_cmd_t  cmd
);
  import obf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_POP) begin
            state_next = (status.empty || status.elem_zero) ? ST_FINISH : ST_POP;
          end else begin
            state_next = status.elem_zero ? ST_FINISH : ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (status.last_idx) begin
          state_next = ST_FINISH;
        end
      end
      ST_POP: begin
        if (status.last_idx || status.last_pop_byte) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_PUSH: begin
        cmd.push_step = 1'b1;
      end
      ST_POP: begin
        cmd.pop_step = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_FINISH: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/core/obf_datapath.sv
module obf_datapath #(
  parameter int CAPACITY          = obf_pkg::DEF_CAPACITY,
  parameter int MAX_ELEMENT_BYTES = obf_pkg::DEF_MAX_ELEMENT_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [obf_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [obf_pkg::CDATA_W-1:0]   cfg_data,
  input  logic                          req_type,
  input  logic [obf_pkg::DATA_W-1:0]    push_data,
  input  logic                          out_ready,
  input  obf_pkg::ctrl_cmd_t            cmd,
  output obf_pkg::dp_status_t           status,
  output logic                          out_valid,
  output logic [obf_pkg::DATA_W-1:0]    pop_data,
  output logic [obf_pkg::ELEM_W-1:0]    bytes_popped,
  output logic [obf_pkg::SIZE_W-1:0]    fill_count,
  output logic                          is_empty,
  output logic                          is_full
);
  import obf_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
  localparam int CAP9  = (CAPACITY > 511) ? 511 : CAPACITY;
  localparam int LANES = DATA_W / 8;

  // Configuration
  logic [ELEM_W-1:0] element_bytes;
  logic [SIZE_W-1:0] ring_size;

  // Ring state
  logic [AW-1:0]     head;
  logic [SIZE_W-1:0] count;
  logic [ELEM_W-1:0] idx;
  logic              req_pop;

  // Payload
  logic [7:0]        mem [CAPACITY];
  logic [7:0]        rd_data;
  logic [DATA_W-1:0] push_buf;
  logic [DATA_W-1:0] gather;
  logic              cap_pend;
  logic [2:0]        cap_lane;

  logic [SIZE_W-1:0] size;
  logic [ELEM_W-1:0] elem;
  logic [CW-1:0]     size_w;
  logic [CW-1:0]     sum;
  logic [CW-1:0]     slot;
  logic [CW-1:0]     head_inc;
  logic [AW-1:0]     head_adv;

  // Clamp the registers to their usable ranges
  always_comb begin
    if (ring_size == '0) begin
      size = SIZE_W'(1);
    end else if (ring_size > SIZE_W'(CAP9)) begin
      size = SIZE_W'(CAP9);
    end else begin
      size = ring_size;
    end
    elem = (element_bytes > ELEM_W'(MAX_ELEMENT_BYTES)) ? ELEM_W'(MAX_ELEMENT_BYTES)
                                                        : element_bytes;
  end

  // Tail slot and head advance, both wrap at the ring size
  always_comb begin
    size_w   = CW'(size);
    sum      = CW'(head) + CW'(count);
    slot     = (sum >= size_w) ? (sum - size_w) : sum;
    head_inc = CW'(head) + CW'(1);
    head_adv = (head_inc >= size_w) ? '0 : head_inc[AW-1:0];
  end

  always_comb begin
    status.elem_zero     = (elem == '0);
    status.empty         = (count == '0);
    status.last_idx      = ({1'b0, idx} + (ELEM_W+1)'(1)) == {1'b0, elem};
    status.last_pop_byte = (count == SIZE_W'(1));
    status.out_free      = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_bytes <= ELEM_W'(1);
      ring_size     <= SIZE_W'(256);
      head          <= '0;
      count         <= '0;
      idx           <= '0;
      req_pop       <= 1'b0;
      cap_pend      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      cap_pend <= cmd.pop_step;
      if (cfg_we) begin
        case (cfg_index)
          REG_ELEMENT_BYTES: element_bytes <= cfg_data[ELEM_W-1:0];
          REG_RING_SIZE: begin
            ring_size <= cfg_data[SIZE_W-1:0];
            head      <= '0;
            count     <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.start) begin
        idx     <= '0;
        req_pop <= req_type;
      end
      if (cmd.push_step) begin
        idx <= idx + ELEM_W'(1);
        if (count < size) begin
          count <= count + SIZE_W'(1);
        end else begin
          head <= head_adv;
        end
      end
      if (cmd.pop_step) begin
        idx   <= idx + ELEM_W'(1);
        count <= count - SIZE_W'(1);
        head  <= head_adv;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Byte store: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.push_step) begin
      mem[slot[AW-1:0]] <= push_buf[8*idx[2:0] +: 8];
    end
    if (cmd.pop_step) begin
      rd_data <= mem[head];
    end
  end

  // Gather popped bytes in the cycle after the read
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      push_buf <= push_data;
    end
    if (cmd.pop_step) begin
      cap_lane <= idx[2:0];
    end
    for (int l = 0; l < LANES; l++) begin
      if (cmd.start) begin
        gather[8*l +: 8] <= '0;
      end else if (cap_pend && (cap_lane == 3'(l))) begin
        gather[8*l +: 8] <= rd_data;
      end
    end
    if (cmd.load_out) begin
      pop_data     <= gather;
      bytes_popped <= req_pop ? idx : '0;
      fill_count   <= count;
      is_empty     <= (count == '0);
      is_full      <= (count >= size);
    end
  end

endmodule

// File: rtl/core/overwriting_byte_fifo.sv
// Channel  Dir  Handshake             Word
// -------  ---  --------------------  -------------------------------------------
// in       in   in_valid / in_ready   req_type, push_data
// out      out  out_valid / out_ready pop_data, bytes_popped, fill_count,
//                                     is_empty, is_full
// cfg      in   cfg_we (no wait)      cfg_index, cfg_data
//
// Sequence: one byte store access per cycle. A push steps once per element byte,
//   a pop once per byte actually popped and then drains the registered read of
//   the store; both then load the result, as does an empty pop or zero-size element.
// The output register frees the input side: a new word is taken while the last
//   result still waits for out_ready; only its load stalls on a full register.
// Reset: synchronous; ring empty, head at slot 0, element_bytes 1, ring_size
//   256. The byte store is not cleared; counting keeps stale slots unread.
// Writing ring_size flushes the ring (head and count back to zero).
module overwriting_byte_fifo #(
  parameter int CAPACITY          = obf_pkg::DEF_CAPACITY,
  parameter int MAX_ELEMENT_BYTES = obf_pkg::DEF_MAX_ELEMENT_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [obf_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [obf_pkg::CDATA_W-1:0]   cfg_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [obf_pkg::DATA_W-1:0]    push_data,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [obf_pkg::DATA_W-1:0]    pop_data,
  output logic [obf_pkg::ELEM_W-1:0]    bytes_popped,
  output logic [obf_pkg::SIZE_W-1:0]    fill_count,
  output logic                          is_empty,
  output logic                          is_full
);
  import obf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: dispatch, byte loop, drain, result load
  obf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Ring pointers, byte store, gather register and output register
  obf_datapath #(
    .CAPACITY          (CAPACITY),
    .MAX_ELEMENT_BYTES (MAX_ELEMENT_BYTES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .push_data    (push_data),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .pop_data     (pop_data),
    .bytes_popped (bytes_popped),
    .fill_count   (fill_count),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

endmodule

// File: bench/tb_overwriting_byte_fifo.sv
`timescale 1ns / 1ps

module tb_overwriting_byte_fifo;
  import obf_pkg::*;

  localparam int CAP           = DEF_CAPACITY;
  localparam int MAX_ELEM      = DEF_MAX_ELEMENT_BYTES;
  localparam int HOLD_CYCLES   = 120;   // long receiver hold-off
  localparam int QUIET_LIMIT   = 2000;  // cycles with no word moved before giving up
  localparam int SETTLE_CYCLES = 16;    // > worst request latency
  localparam int N_PHASES      = 12;
  localparam int PHASE_WORDS   = 96;
  localparam int HOLD_PHASE    = 6;
  localparam int PAUSE_PHASE   = 9;
  localparam int MAX_PRINTS    = 100;

  // One result word, field by field
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [ELEM_W-1:0] nbytes;
    logic [SIZE_W-1:0] fill;
    logic              empty;
    logic              full;
  } fifo_reply_t;

  // Directed script row: either a register write or a request word
  typedef struct {
    bit                 is_cfg;
    logic [CIDX_W-1:0]  reg_idx;
    logic [CDATA_W-1:0] reg_val;
    logic               req;
    logic [DATA_W-1:0]  data;
    bit                 typed;   // reply typed in by hand
    fifo_reply_t        reply;
  } script_row_t;

  // DUT ports; the inputs are known from time zero
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_we    = 1'b0;
  logic [CIDX_W-1:0]  cfg_index = '0;
  logic [CDATA_W-1:0] cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               req_type  = REQ_PUSH;
  logic [DATA_W-1:0]  push_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [DATA_W-1:0]  pop_data;
  logic [ELEM_W-1:0]  bytes_popped;
  logic [SIZE_W-1:0]  fill_count;
  logic               is_empty;
  logic               is_full;

  // Hand-typed reply travels with the word, sampled at acceptance
  bit          typed_on    = 1'b0;
  fifo_reply_t typed_reply = '0;

  // Ring model state
  logic [7:0]        ring_mem [CAP];
  int unsigned       ring_head;
  int unsigned       ring_count;
  logic [ELEM_W-1:0] elem_reg;
  logic [SIZE_W-1:0] size_reg;

  fifo_reply_t replies_due [$];
  script_row_t script [$];

  int unsigned mismatches       = 0;
  int unsigned words_sent       = 0;
  int unsigned results_checked  = 0;
  int unsigned settings_applied = 0;
  int unsigned holds_done       = 0;
  int unsigned quiet_cycles     = 0;

  // Idling knobs for sender and receiver
  bit tx_gaps_on    = 1'b1;
  bit rx_stalls_on  = 1'b1;
  bit hold_off_req  = 1'b0;

  overwriting_byte_fifo dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .push_data    (push_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pop_data     (pop_data),
    .bytes_popped (bytes_popped),
    .fill_count   (fill_count),
    .is_empty     (is_empty),
    .is_full      (is_full)
  );

  always #5 clk = ~clk;

  // Ring behavior for one request word; updates the model state.
  // Push: bytes go to head+count; once full, each byte replaces the oldest
  // and the head moves on. Pop: up to one element from the head, stopping
  // when the ring runs dry.
  function automatic fifo_reply_t fifo_apply_request(logic req, logic [DATA_W-1:0] data);
    fifo_reply_t r;
    int unsigned size;
    int unsigned elem;
    int unsigned slot;
    int unsigned i;
    size = (size_reg == 0) ? 1 : ((size_reg > CAP) ? CAP : size_reg);
    elem = (elem_reg > MAX_ELEM) ? MAX_ELEM : elem_reg;
    r = '0;
    if (req == REQ_PUSH) begin
      for (i = 0; i < elem; i++) begin
        slot = ring_head + ring_count;
        if (slot >= size) slot -= size;
        ring_mem[slot] = data[8*i +: 8];
        if (ring_count < size) begin
          ring_count++;
        end else begin
          ring_head++;
          if (ring_head >= size) ring_head = 0;
        end
      end
    end else begin
      for (i = 0; i < elem && ring_count > 0; i++) begin
        r.data[8*i +: 8] = ring_mem[ring_head];
        r.nbytes = r.nbytes + 1'b1;
        ring_count--;
        ring_head++;
        if (ring_head >= size) ring_head = 0;
      end
    end
    r.fill  = ring_count[SIZE_W-1:0];
    r.empty = (ring_count == 0);
    r.full  = (ring_count >= size);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t: result %0d %s: got 0x%0h, expected 0x%0h",
               $time, results_checked, what, got, want);
  endtask

  function automatic fifo_reply_t reply_of(logic [DATA_W-1:0] data, logic [ELEM_W-1:0] n,
                                           logic [SIZE_W-1:0] fill, logic empty, logic full);
    fifo_reply_t r;
    r.data   = data;
    r.nbytes = n;
    r.fill   = fill;
    r.empty  = empty;
    r.full   = full;
    return r;
  endfunction

  function automatic script_row_t row_cfg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
    script_row_t r;
    r = '{default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic script_row_t row_req(logic req, logic [DATA_W-1:0] data, bit typed,
                                          fifo_reply_t reply);
    script_row_t r;
    r = '{default: '0};
    r.req   = req;
    r.data  = data;
    r.typed = typed;
    r.reply = reply;
    return r;
  endfunction

  // Offer one word after a random gap and hold it until taken.
  task automatic send_word(logic req, logic [DATA_W-1:0] data, bit typed, fifo_reply_t reply);
    int unsigned n;
    n = tx_gaps_on ? $urandom_range(0, 14) : 0;
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    push_data   <= data;
    typed_on    <= typed;
    typed_reply <= reply;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
  endtask

  // Stop offering and wait until every outstanding reply is back.
  task automatic wait_for_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
    @(posedge clk);
  endtask

  // Monitor: model follows register writes and accepted words; results are
  // compared in order against the oldest pending reply.
  always @(posedge clk) begin : monitor
    fifo_reply_t want;
    if (rst) begin
      ring_head  = 0;
      ring_count = 0;
      elem_reg   = 4'd1;
      size_reg   = 9'd256;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ELEMENT_BYTES) begin
          elem_reg = cfg_data[ELEM_W-1:0];
        end else if (cfg_index == REG_RING_SIZE) begin
          // ring size write flushes the ring
          size_reg   = cfg_data[SIZE_W-1:0];
          ring_head  = 0;
          ring_count = 0;
        end
      end
      if (in_valid && in_ready) begin
        want = fifo_apply_request(req_type, push_data);
        replies_due.push_back(typed_on ? typed_reply : want);
        words_sent++;
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result with no word pending", DATA_W'(fill_count), '0);
        end else begin
          want = replies_due.pop_front();
          if (pop_data !== want.data)       report_mismatch("pop_data", pop_data, want.data);
          if (bytes_popped !== want.nbytes) report_mismatch("bytes_popped",
                                                            DATA_W'(bytes_popped),
                                                            DATA_W'(want.nbytes));
          if (fill_count !== want.fill)     report_mismatch("fill_count", DATA_W'(fill_count),
                                                            DATA_W'(want.fill));
          if (is_empty !== want.empty)      report_mismatch("is_empty", DATA_W'(is_empty),
                                                            DATA_W'(want.empty));
          if (is_full !== want.full)        report_mismatch("is_full", DATA_W'(is_full),
                                                            DATA_W'(want.full));
        end
        results_checked++;
      end
    end
  end

  // Watchdog: any accepted word on either side counts as progress
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random stalls per result; one long hold-off on request so the
  // output register and the core back up into the input side.
  initial begin : receiver
    int unsigned n;
    wait (rst == 1'b0);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        n = HOLD_CYCLES;
        holds_done++;
      end else begin
        n = rx_stalls_on ? $urandom_range(0, 14) : 0;
      end
      if (n != 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned        p;
    int unsigned        k;
    logic               req;
    logic [CDATA_W-1:0] reg_val;
    int                 phase_size [N_PHASES];
    int                 phase_elem [N_PHASES];
    int                 phase_push [N_PHASES];

    // Ring sizes 0 and above 256 clamp; element sizes above 8 too
    phase_size = '{256, 1, 2, 0, 511, 7, 256, 300, 16, 3, 100, 256};
    phase_elem = '{8, 1, 15, 3, 0, 5, 8, 2, 4, 7, 6, 8};
    phase_push = '{85, 50, 40, 70, 50, 60, 80, 50, 65, 55, 50, 30};

    // --- directed script ---
    // pop right after reset: nothing stored
    script.push_back(row_req(REQ_POP, '0, 1, reply_of('0, 0, 0, 1, 0)));
    script.push_back(row_cfg(REG_ELEMENT_BYTES, 9'd8));
    // widest elements, all ones and all zeros
    script.push_back(row_req(REQ_PUSH, '1, 1, reply_of('0, 0, 8, 0, 0)));
    script.push_back(row_req(REQ_PUSH, '0, 1, reply_of('0, 0, 16, 0, 0)));
    script.push_back(row_req(REQ_POP, '0, 1, reply_of('1, 8, 8, 0, 0)));
    script.push_back(row_req(REQ_POP, '0, 1, reply_of('0, 8, 0, 1, 0)));
    // ring size zero acts as one slot: every extra byte overwrites
    script.push_back(row_cfg(REG_RING_SIZE, 9'd0));
    script.push_back(row_cfg(REG_ELEMENT_BYTES, 9'd3));
    script.push_back(row_req(REQ_PUSH, 64'hFFFF_FFFF_FFCC_BBAA, 1,
                             reply_of('0, 0, 1, 0, 1)));
    // partial element left: pop stops after one byte
    script.push_back(row_req(REQ_POP, '0, 1, reply_of(64'hCC, 1, 0, 1, 0)));
    // oversized ring and element clamp to 256 and 8
    script.push_back(row_cfg(REG_RING_SIZE, 9'd511));
    script.push_back(row_cfg(REG_ELEMENT_BYTES, 9'h1FF));
    script.push_back(row_req(REQ_PUSH, 64'h8877_6655_4433_2211, 1,
                             reply_of('0, 0, 8, 0, 0)));
    script.push_back(row_req(REQ_POP, '0, 1,
                             reply_of(64'h8877_6655_4433_2211, 8, 0, 1, 0)));
    // zero-byte elements: push stores nothing, pop delivers nothing
    script.push_back(row_cfg(REG_ELEMENT_BYTES, 9'd0));
    script.push_back(row_req(REQ_PUSH, 64'hA5A5_A5A5_A5A5_A5A5, 1,
                             reply_of('0, 0, 0, 1, 0)));
    script.push_back(row_req(REQ_POP, '0, 1, reply_of('0, 0, 0, 1, 0)));
    // five-slot ring, two-byte elements: wrap and overwrite of the oldest byte
    script.push_back(row_cfg(REG_RING_SIZE, 9'd5));
    script.push_back(row_cfg(REG_ELEMENT_BYTES, 9'd2));
    script.push_back(row_req(REQ_PUSH, 64'h1122, 1, reply_of('0, 0, 2, 0, 0)));
    script.push_back(row_req(REQ_PUSH, 64'h3344, 1, reply_of('0, 0, 4, 0, 0)));
    script.push_back(row_req(REQ_PUSH, 64'h5566, 1, reply_of('0, 0, 5, 0, 1)));
    script.push_back(row_req(REQ_POP, '0, 1, reply_of(64'h4411, 2, 3, 0, 0)));
    script.push_back(row_req(REQ_POP, '0, 1, reply_of(64'h6633, 2, 1, 0, 0)));
    script.push_back(row_req(REQ_POP, '0, 1, reply_of(64'h55, 1, 0, 1, 0)));
    // upper write bits ignored for element size (0x1F4 -> 4)
    script.push_back(row_cfg(REG_ELEMENT_BYTES, 9'h1F4));
    script.push_back(row_req(REQ_PUSH, 64'hDEAD_BEEF_CAFE_F00D, 0, '0));
    script.push_back(row_req(REQ_POP, '0, 0, '0));
    // ring size write flushes stored bytes
    script.push_back(row_req(REQ_PUSH, 64'h0123_4567_89AB_CDEF, 0, '0));
    script.push_back(row_cfg(REG_RING_SIZE, 9'd256));
    script.push_back(row_req(REQ_POP, '0, 1, reply_of('0, 0, 0, 1, 0)));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[k]) begin
      if (script[k].is_cfg) begin
        wait_for_replies();
        write_reg(script[k].reg_idx, script[k].reg_val);
      end else begin
        send_word(script[k].req, script[k].data, script[k].typed, script[k].reply);
      end
    end

    // --- random phases, one element size and ring size setting each ---
    for (p = 0; p < N_PHASES; p++) begin
      wait_for_replies();
      reg_val      = CDATA_W'($urandom_range(0, 511));
      reg_val[3:0] = ELEM_W'(phase_elem[p]);
      write_reg(REG_ELEMENT_BYTES, reg_val);
      write_reg(REG_RING_SIZE, CDATA_W'(phase_size[p]));
      // phase 0 runs flat out; the hold-off phase keeps the sender eager
      tx_gaps_on   = (p != 0) && ($urandom_range(0, 3) != 0);
      rx_stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
      if (p == HOLD_PHASE) tx_gaps_on = 1'b0;
      for (k = 0; k < PHASE_WORDS; k++) begin
        if (p == HOLD_PHASE && k == 20) hold_off_req = 1'b1;
        if (p == PAUSE_PHASE && k == PHASE_WORDS / 2) wait_for_replies();
        req = ($urandom_range(0, 99) < phase_push[p]) ? REQ_PUSH : REQ_POP;
        send_word(req, {$urandom, $urandom}, 1'b0, '0);
      end
    end

    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (replies_due.size() != 0)
      report_mismatch("replies never delivered", DATA_W'(replies_due.size()), '0);

    $display("Sent %0d words over %0d register writes (ring sizes 0..511, element sizes 0..15),",
             words_sent, settings_applied);
    $display("compared %0d results, with random gaps and %0d long receiver hold-off.",
             results_checked, holds_done);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
